/* rtl/scfb_pkg.sv */
`default_nettype none

package scfb_pkg;

  // command codes of the input word
  typedef enum logic [1:0] {
    CMD_MOVE    = 2'd0,
    CMD_HOME    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // frame constants
  localparam logic [7:0]  FC_MULTI_WRITE  = 8'h6A;
  localparam logic [7:0]  FC_READ         = 8'h69;
  localparam logic [7:0]  FC_SINGLE_WRITE = 8'h06;
  localparam logic [15:0] REG_POS_BASE    = 16'h0100;
  localparam logic [15:0] REG_FORCE_BASE  = 16'h0106;
  localparam logic [15:0] REG_SPEED_BASE  = 16'h010C;
  localparam logic [15:0] REG_HOMING      = 16'h0100;
  localparam logic [15:0] MOVE_FRAME_LEN  = 16'h0015;
  localparam logic [15:0] MOVE_DATA_LEN   = 16'h000D;
  localparam logic [7:0]  MOVE_PAIRS      = 8'h03;
  localparam logic [4:0]  MOVE_BYTES      = 5'd21;
  localparam logic [4:0]  HOME_BYTES      = 5'd8;
  localparam logic [4:0]  READ_BASE_BYTES = 5'd9;
  localparam logic [4:0]  HDR_BYTES       = 5'd7;
  localparam logic [2:0]  FIT_REGS        = 3'd6;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  // controller -> datapath
  typedef struct packed {
    logic ready;
    logic load;
    logic emit;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic cmd_ok;
    logic out_free;
    logic last;
  } sts_t;

  // crc-16/modbus over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/scfb_if.sv */
`default_nettype none

interface scfb_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  finger;
  logic [15:0] position;
  logic [15:0] force_req;
  logic [15:0] speed;
  logic [15:0] homing_pattern;
  logic [15:0] start_register;
  logic [2:0]  register_count;

  modport source (
    output valid, command, finger, position, force_req, speed,
           homing_pattern, start_register, register_count,
    input  ready
  );
  modport sink (
    input  valid, command, finger, position, force_req, speed,
           homing_pattern, start_register, register_count,
    output ready
  );
endinterface

interface scfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/scfb_ctrl.sv */
`default_nettype none

module scfb_ctrl
  import scfb_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        ctl_o.ready = 1'b1;
        if (sts_i.in_valid) begin
          ctl_o.load = 1'b1;
          // unknown command: taken and dropped
          if (sts_i.cmd_ok) begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ctl_o.emit = sts_i.out_free;
        if (sts_i.out_free && sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/scfb_dp.sv */
`default_nettype none

module scfb_dp
  import scfb_pkg::*;
#(
  parameter int MAX_READ_REGS = 6
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [7:0]   cfg_wdata_i,
  scfb_cmd_if.sink     cmd_i,
  scfb_frame_if.source frame_o,
  input  ctl_t         ctl_i,
  output sts_t         sts_o
);

  localparam logic [2:0] MaxRegs =
    (MAX_READ_REGS < 6) ? 3'(MAX_READ_REGS) : FIT_REGS;

  logic [7:0]  dev_id_q;
  cmd_e        cmd_q;
  logic [2:0]  finger_q;
  logic [15:0] pos_q, force_q, speed_q, pat_q, start_q;
  logic [2:0]  cnt_q, cnt_d;
  logic [4:0]  idx_q;
  logic [15:0] crc_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic [4:0]  len;
  logic [4:0]  off;
  logic [2:0]  wsel;
  logic [15:0] word;
  logic [7:0]  cur_byte;
  logic        is_crc;

  assign cmd_i.ready      = ctl_i.ready;
  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.last_byte  = out_last_q;

  assign sts_o.in_valid = cmd_i.valid;
  assign sts_o.cmd_ok   = (cmd_e'(cmd_i.command) == CMD_MOVE) ||
                          (cmd_e'(cmd_i.command) == CMD_HOME) ||
                          (cmd_e'(cmd_i.command) == CMD_READ);
  assign sts_o.out_free = !out_valid_q || frame_o.ready;
  assign sts_o.last     = (idx_q == len - 5'd1);

  // register count clamp
  always_comb begin
    cnt_d = cmd_i.register_count;
    if (cnt_d == 3'd0) begin
      cnt_d = 3'd1;
    end
    if (cnt_d > MaxRegs) begin
      cnt_d = MaxRegs;
    end
  end

  always_comb begin
    case (cmd_q)
      CMD_MOVE: len = MOVE_BYTES;
      CMD_HOME: len = HOME_BYTES;
      CMD_READ: len = READ_BASE_BYTES + {1'b0, cnt_q, 1'b0};
      default:  len = MOVE_BYTES;
    endcase
  end

  // payload words after the seven header bytes
  assign off  = idx_q - HDR_BYTES;
  assign wsel = off[3:1];

  always_comb begin
    case (cmd_q)
      CMD_READ: word = start_q + {13'd0, wsel};
      default: begin
        case (wsel)
          3'd0:    word = REG_POS_BASE + {13'd0, finger_q};
          3'd1:    word = pos_q;
          3'd2:    word = REG_FORCE_BASE + {13'd0, finger_q};
          3'd3:    word = force_q;
          3'd4:    word = REG_SPEED_BASE + {13'd0, finger_q};
          default: word = speed_q;
        endcase
      end
    endcase
  end

  assign is_crc = (idx_q >= len - 5'd2);

  always_comb begin
    cur_byte = dev_id_q;
    if (idx_q == len - 5'd2) begin
      cur_byte = crc_q[7:0];
    end else if (idx_q == len - 5'd1) begin
      cur_byte = crc_q[15:8];
    end else begin
      case (cmd_q)
        CMD_HOME: begin
          case (idx_q)
            5'd0:    cur_byte = dev_id_q;
            5'd1:    cur_byte = FC_SINGLE_WRITE;
            5'd2:    cur_byte = REG_HOMING[15:8];
            5'd3:    cur_byte = REG_HOMING[7:0];
            5'd4:    cur_byte = pat_q[15:8];
            default: cur_byte = pat_q[7:0];
          endcase
        end
        CMD_READ: begin
          case (idx_q)
            5'd0:    cur_byte = dev_id_q;
            5'd1:    cur_byte = 8'h00;
            5'd2:    cur_byte = {3'd0, len};
            5'd3:    cur_byte = FC_READ;
            5'd4:    cur_byte = 8'h00;
            5'd5:    cur_byte = {4'd0, cnt_q, 1'b1};
            5'd6:    cur_byte = {5'd0, cnt_q};
            default: cur_byte = off[0] ? word[7:0] : word[15:8];
          endcase
        end
        default: begin
          case (idx_q)
            5'd0:    cur_byte = dev_id_q;
            5'd1:    cur_byte = MOVE_FRAME_LEN[15:8];
            5'd2:    cur_byte = MOVE_FRAME_LEN[7:0];
            5'd3:    cur_byte = FC_MULTI_WRITE;
            5'd4:    cur_byte = MOVE_DATA_LEN[15:8];
            5'd5:    cur_byte = MOVE_DATA_LEN[7:0];
            5'd6:    cur_byte = MOVE_PAIRS;
            default: cur_byte = off[0] ? word[7:0] : word[15:8];
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q    <= 8'd1;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      crc_q       <= CRC_INIT;
    end else begin
      if (cfg_we_i) begin
        dev_id_q <= cfg_wdata_i;
      end
      if (ctl_i.load) begin
        idx_q <= '0;
        crc_q <= CRC_INIT;
      end else if (ctl_i.emit) begin
        idx_q <= idx_q + 5'd1;
        if (!is_crc) begin
          crc_q <= crc_byte(crc_q, cur_byte);
        end
      end
      if (ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= cmd_e'(cmd_i.command);
      finger_q <= cmd_i.finger;
      pos_q    <= cmd_i.position;
      force_q  <= cmd_i.force_req;
      speed_q  <= cmd_i.speed;
      pat_q    <= cmd_i.homing_pattern;
      start_q  <= cmd_i.start_register;
      cnt_q    <= cnt_d;
    end
    if (ctl_i.emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= sts_o.last;
    end
  end

endmodule

`default_nettype wire

/* rtl/servo_command_frame_builder.sv */
// servo command frame builder: takes one command word (move finger, homing write or
// register read) and sends the whole serial frame out one byte word at a time, device id
// first and crc-16/modbus last, low byte then high byte, the high byte flagged with
// last_byte. after a command is taken, its n bytes are loaded into the output register
// one byte per cycle while the sink does not stall, n being 21 for a move, 8 for homing
// and 9 + 2 * count for a read; the crc is folded in as each byte is loaded.
// a new command is taken in the cycle after the final crc byte is loaded, while that byte
// may still wait in the output register. a command code of 3 is taken and produces no
// bytes. the device id register resets to 1; the user must write it only while no frame
// is in flight, and the block itself does not enforce this.
`default_nettype none

module servo_command_frame_builder
  import scfb_pkg::*;
#(
  parameter int MAX_READ_REGS = 6  // read count saturates here, and never above six
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // device id register
  input  wire          cfg_we_i,
  input  wire  [7:0]   cfg_wdata_i,
  // command words in, frame byte words out
  scfb_cmd_if.sink     cmd_i,
  scfb_frame_if.source frame_o
);

  ctl_t ctl;
  sts_t sts;

  // sequencer: idle / run, one frame at a time
  scfb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // field capture, byte selection, crc and output register
  scfb_dp #(
    .MAX_READ_REGS (MAX_READ_REGS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .frame_o     (frame_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

/* rtl/scfb_checker.sv */
`default_nettype none

module scfb_checker
  import scfb_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire [1:0] in_command_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [7:0] out_byte_i,
  input wire       out_last_i
);

  // a stalled byte word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled frame byte changed");

  // a real command starts a frame and blocks the input
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i != CMD_UNKNOWN |=> !in_ready_i)
    else $error("input ready while frame starts");

  // unknown command is dropped, input stays open
  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i == CMD_UNKNOWN |=> in_ready_i)
    else $error("unknown command stalled input");

  // mid-frame byte pending means the frame is not finished
  a_no_accept_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a frame");

endmodule

bind servo_command_frame_builder scfb_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .in_command_i (cmd_i.command),
  .out_valid_i  (frame_o.valid),
  .out_ready_i  (frame_o.ready),
  .out_byte_i   (frame_o.frame_byte),
  .out_last_i   (frame_o.last_byte)
);

`default_nettype wire
